### src/go_to_goal_velocity_controller_macros.svh
// Assertion helpers used by the top-level controller RTL.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GGVC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GGVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ggvc_pkg.sv
`default_nettype none

package ggvc_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int IDX_W         = 5;
  localparam int LATENCY       = CORDIC_STAGES + 4;

  localparam int XY_W = 36;   // CORDIC x/y, inputs scaled by 256 plus growth
  localparam int Z_W  = 35;   // Q30 angle accumulator
  localparam int SQ_W = 47;   // one squared coordinate
  localparam int D2_W = 48;   // squared distance / squared radius
  localparam int B_W  = 21;   // Q16 bearing, signed
  localparam int MAG_W = 20;  // Q16 bearing magnitude
  localparam int PROD_W = 36; // magnitude * turn gain

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_RADIUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RADIUS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED     = 3'd5;

  // reset values
  localparam logic [16:0] RST_HEADING_DEADBAND = 17'd1144;
  localparam logic [15:0] RST_TURN_GAIN        = 16'd51472;
  localparam logic [23:0] RST_STOP_RADIUS      = 24'd6554;
  localparam logic [23:0] RST_SLOW_RADIUS      = 24'd196608;
  localparam logic [15:0] RST_SLOW_SPEED       = 16'd19661;
  localparam logic [15:0] RST_CRUISE_SPEED     = 16'd32768;

  typedef struct packed {
    logic signed [23:0] goal_forward;
    logic signed [23:0] goal_left;
  } ggvc_in_t;

  typedef struct packed {
    logic signed [18:0] angular_speed;
    logic [15:0]        linear_speed;
    logic               turning;
  } ggvc_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        xx;
    logic [SQ_W-1:0]        yy;
  } ggvc_word_t;

  typedef struct packed {
    logic       valid;
    ggvc_word_t word;
  } ggvc_stage_t;

  typedef struct packed {
    logic [16:0]     heading_deadband;
    logic [15:0]     turn_gain;
    logic [15:0]     slow_speed;
    logic [15:0]     cruise_speed;
    logic [D2_W-1:0] stop_sq;
    logic [D2_W-1:0] slow_sq;
  } ggvc_cfg_t;

  // truncated atan(2^-i) in Q30
  function automatic logic [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [Z_W-1:0] a;
    case (i)
      5'd0:    a = 35'd843314856;
      5'd1:    a = 35'd497837829;
      5'd2:    a = 35'd263043836;
      5'd3:    a = 35'd133525158;
      5'd4:    a = 35'd67021686;
      5'd5:    a = 35'd33543515;
      5'd6:    a = 35'd16775850;
      5'd7:    a = 35'd8388437;
      5'd8:    a = 35'd4194282;
      5'd9:    a = 35'd2097149;
      5'd10:   a = 35'd1048575;
      5'd11:   a = 35'd524287;
      5'd12:   a = 35'd262143;
      5'd13:   a = 35'd131071;
      5'd14:   a = 35'd65535;
      5'd15:   a = 35'd32767;
      5'd16:   a = 35'd16383;
      5'd17:   a = 35'd8191;
      5'd18:   a = 35'd4095;
      5'd19:   a = 35'd2047;
      5'd20:   a = 35'd1023;
      5'd21:   a = 35'd511;
      5'd22:   a = 35'd255;
      5'd23:   a = 35'd127;
      5'd24:   a = 35'd63;
      5'd25:   a = 35'd31;
      5'd26:   a = 35'd15;
      5'd27:   a = 35'd7;
      5'd28:   a = 35'd3;
      5'd29:   a = 35'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### src/ggvc_prep.sv
`default_nettype none

module ggvc_prep import ggvc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire ggvc_in_t    goal_i,
  output ggvc_stage_t      stage_o
);

  logic               valid_q;
  ggvc_word_t         word_d, word_q;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [47:0] xsq, ysq;

  always_comb begin
    xs  = XY_W'(signed'({goal_i.goal_forward, 8'd0}));
    ys  = XY_W'(signed'({goal_i.goal_left, 8'd0}));
    xsq = goal_i.goal_forward * goal_i.goal_forward;
    ysq = goal_i.goal_left * goal_i.goal_left;
    word_d.xx = xsq[SQ_W-1:0];
    word_d.yy = ysq[SQ_W-1:0];
    // rear half plane: rotate by pi first
    if (xs[XY_W-1]) begin
      word_d.x = -xs;
      word_d.y = -ys;
      word_d.z = ys[XY_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      word_d.x = xs;
      word_d.y = ys;
      word_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      word_q <= word_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule

`default_nettype wire

### src/ggvc_cell.sv
`default_nettype none

module ggvc_cell import ggvc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire ggvc_stage_t      stage_i,
  output ggvc_stage_t           stage_o
);

  logic                   valid_q;
  ggvc_word_t             word_d, word_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  ang;
  logic                   y_pos, y_neg;

  always_comb begin
    dx     = stage_i.word.y >>> idx_i;
    dy     = stage_i.word.x >>> idx_i;
    ang    = $signed(atan_q30(idx_i));
    y_neg  = stage_i.word.y[XY_W-1];
    y_pos  = !y_neg && (stage_i.word.y != '0);
    word_d = stage_i.word;
    if (y_pos) begin
      word_d.x = stage_i.word.x + dx;
      word_d.y = stage_i.word.y - dy;
      word_d.z = stage_i.word.z + ang;
    end else if (y_neg) begin
      word_d.x = stage_i.word.x - dx;
      word_d.y = stage_i.word.y + dy;
      word_d.z = stage_i.word.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      word_q <= word_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule

`default_nettype wire

### src/ggvc_post.sv
`default_nettype none

module ggvc_post import ggvc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ggvc_stage_t stage_i,
  input  wire ggvc_cfg_t   cfg_i,
  output logic             valid_o,
  output ggvc_out_t        result_o
);

  // stage 1: round angle, magnitude, distance sum
  logic                   v1_q, v2_q, v3_q;
  logic signed [Z_W-1:0]  zr;
  logic signed [B_W-1:0]  b;
  logic signed [B_W-1:0]  b_abs;
  logic [MAG_W-1:0]       mag_d, mag_q;
  logic                   neg_q, turn1_q;
  logic [D2_W-1:0]        d2_d, d2_q;
  logic                   turn1_d;

  always_comb begin
    zr      = stage_i.word.z + Z_W'(8192);
    b       = zr[Z_W-1:14];
    b_abs   = b[B_W-1] ? -b : b;
    mag_d   = b_abs[MAG_W-1:0];
    d2_d    = D2_W'(stage_i.word.xx) + D2_W'(stage_i.word.yy);
    turn1_d = mag_d > MAG_W'(cfg_i.heading_deadband);
  end

  // stage 2: gain product and radius tests
  logic [PROD_W-1:0] prod_q;
  logic              neg2_q, turn2_q;
  logic [15:0]       lin_d, lin_q;

  always_comb begin
    if (turn1_q || d2_q < cfg_i.stop_sq) begin
      lin_d = '0;
    end else if (d2_q < cfg_i.slow_sq) begin
      lin_d = cfg_i.slow_speed;
    end else begin
      lin_d = cfg_i.cruise_speed;
    end
  end

  // stage 3: round half away from zero, apply sign
  logic [PROD_W:0]       rnd;
  logic signed [B_W:0]   p, ang;
  ggvc_out_t             res_d, res_q;

  always_comb begin
    rnd   = {1'b0, prod_q} + (PROD_W+1)'(32768);
    p     = $signed({1'b0, rnd[PROD_W:16]});
    ang   = neg2_q ? -p : p;
    res_d.angular_speed = turn2_q ? ang[18:0] : '0;
    res_d.linear_speed  = lin_q;
    res_d.turning       = turn2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= stage_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      mag_q   <= mag_d;
      neg_q   <= b[B_W-1];
      turn1_q <= turn1_d;
      d2_q    <= d2_d;
    end
    if (v1_q) begin
      prod_q  <= mag_q * cfg_i.turn_gain;
      neg2_q  <= neg_q;
      turn2_q <= turn1_q;
      lin_q   <= lin_d;
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = v3_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### src/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller: turn in place, then drive.
// Command channel: a goal word (goal_forward, goal_left, signed Q16 metres
// in the robot frame) is taken on every rising edge with start high and busy
// low. busy is held low, so a new goal may be issued on every cycle.
// Result channel: result_valid_o strobes for one cycle with the command word
// (angular_speed Q16 rad/s, linear_speed Q16 m/s, turning). Results leave in
// the order goals arrived; the receiver cannot stall them, so it must sample
// on the strobe.
// Pipeline from the accepting edge to the edge that takes the
// result: one input stage, 20 CORDIC cells (one vectoring iteration each,
// data shifts one cell per cycle), then rounding, gain multiply with radius
// compares, and the output register. Throughput is one word per cycle, set
// by the pipelined cell chain.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at the
// edge; unknown indexes are ignored. Write only while no word is in flight.
// Squared radii are registered from the radius registers, so they are refreshed in the cycle after a write.
// Reset (rst_ni, async, active low) empties the pipeline and restores the
// default deadband, turn gain, radii and speeds.
`default_nettype none

`include "go_to_goal_velocity_controller_macros.svh"

module go_to_goal_velocity_controller import ggvc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ggvc_in_t              goal_i,
  output logic                       result_valid_o,
  output ggvc_out_t                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // fully pipelined: never refuses a word
  assign busy = 1'b0;

  // configuration registers
  logic [16:0]     heading_deadband_q;
  logic [15:0]     turn_gain_q;
  logic [23:0]     stop_radius_q;
  logic [23:0]     slow_radius_q;
  logic [15:0]     slow_speed_q;
  logic [15:0]     cruise_speed_q;
  logic [D2_W-1:0] stop_sq_q, slow_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_deadband_q <= RST_HEADING_DEADBAND;
      turn_gain_q        <= RST_TURN_GAIN;
      stop_radius_q      <= RST_STOP_RADIUS;
      slow_radius_q      <= RST_SLOW_RADIUS;
      slow_speed_q       <= RST_SLOW_SPEED;
      cruise_speed_q     <= RST_CRUISE_SPEED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEADING_DEADBAND: heading_deadband_q <= cfg_data_i[16:0];
        REG_TURN_GAIN:        turn_gain_q        <= cfg_data_i[15:0];
        REG_STOP_RADIUS:      stop_radius_q      <= cfg_data_i;
        REG_SLOW_RADIUS:      slow_radius_q      <= cfg_data_i;
        REG_SLOW_SPEED:       slow_speed_q       <= cfg_data_i[15:0];
        REG_CRUISE_SPEED:     cruise_speed_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // squared radii, so distance tests need no square root
  always_ff @(posedge clk_i) begin
    stop_sq_q <= stop_radius_q * stop_radius_q;
    slow_sq_q <= slow_radius_q * slow_radius_q;
  end

  ggvc_cfg_t cfg;
  assign cfg.heading_deadband = heading_deadband_q;
  assign cfg.turn_gain        = turn_gain_q;
  assign cfg.slow_speed       = slow_speed_q;
  assign cfg.cruise_speed     = cruise_speed_q;
  assign cfg.stop_sq          = stop_sq_q;
  assign cfg.slow_sq          = slow_sq_q;

  // input stage: scale, fold the rear half plane, square the coordinates
  ggvc_stage_t chain [CORDIC_STAGES+1];

  ggvc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .goal_i   (goal_i),
    .stage_o  (chain[0])
  );

  // CORDIC vectoring chain, one iteration per cell
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ggvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // bearing rounding, turn decision and speed selection
  ggvc_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (chain[CORDIC_STAGES]),
    .cfg_i    (cfg),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  `GGVC_ASSERT_IMPL(a_turn_no_drive, result_valid_o && result_o.turning, result_o.linear_speed == '0, "linear speed while turning")
  `GGVC_ASSERT_IMPL(a_aligned_no_yaw, result_valid_o && !result_o.turning, result_o.angular_speed == '0, "yaw rate while aligned")
  `GGVC_ASSERT_IMPL(a_latency, result_valid_o, $past(start && rst_ni, LATENCY), "result without a goal")
  `GGVC_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

`default_nettype wire
